### sv/printf_format_streamer_macros.svh
// ---------------------------------------------------------------------------
// printf_format_streamer_macros
// Assertion macros used by the format streamer RTL. They compile to
// nothing when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef PRINTF_FORMAT_STREAMER_MACROS_SVH
`define PRINTF_FORMAT_STREAMER_MACROS_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define PFS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define PFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PFS_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define PFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

### sv/pfs_pkg.sv
// ---------------------------------------------------------------------------
// pfs_pkg
// Types, codes and the digit table of the printf format streamer.
// ---------------------------------------------------------------------------
package pfs_pkg;

  localparam int unsigned OUT_COUNT_W = 24;

  typedef enum logic [1:0] {
    FUNC_FMT = 2'd0,
    FUNC_NUM = 2'd1,
    FUNC_STR = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    DIR_C = 2'd0,
    DIR_U = 2'd1,
    DIR_D = 2'd2,
    DIR_X = 2'd3
  } dir_t;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PERCENT = "%";
  localparam logic [7:0] CH_S       = "s";
  localparam logic [7:0] CH_U       = "u";
  localparam logic [7:0] CH_C       = "c";
  localparam logic [7:0] CH_D       = "d";
  localparam logic [7:0] CH_X       = "x";
  localparam logic [7:0] CH_MINUS   = "-";

  // Element 0 is the leftmost character of the literal.
  localparam logic [0:15][7:0] DIGIT_CHARS = "0123456789abcdef";

  // Request from the control logic to the conversion unit.
  typedef struct packed {
    logic start;
    logic hex;
  } conv_req_t;

  // Status and digit offer from the conversion unit.
  typedef struct packed {
    logic       busy;
    logic       valid;
    logic       last;
    logic [7:0] ch;
  } conv_stat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    return DIGIT_CHARS[d];
  endfunction

endpackage

### sv/pfs_in_if.sv
// ---------------------------------------------------------------------------
// pfs_in_if
// Input channel of the format streamer: format, argument and string beats.
// ---------------------------------------------------------------------------
interface pfs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  data_byte;
  logic [31:0] arg_value;

  modport source (output valid, func, data_byte, arg_value, input ready);
  modport sink (input valid, func, data_byte, arg_value, output ready);
endinterface

### sv/pfs_out_if.sv
// ---------------------------------------------------------------------------
// pfs_out_if
// Result channel of the format streamer: characters and end markers.
// ---------------------------------------------------------------------------
interface pfs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_char;
  logic [23:0] char_count;
  logic        last;

  modport source (output valid, kind, out_char, char_count, last, input ready);
  modport sink (input valid, kind, out_char, char_count, last, output ready);
endinterface

### sv/printf_format_streamer.sv
// ---------------------------------------------------------------------------
// printf_format_streamer
// Streams a printf format string and its arguments into output characters.
// ---------------------------------------------------------------------------
// The block takes format bytes, numeric arguments and string argument bytes
// on the cmd channel and returns one result beat per emitted character on
// the res channel, plus a finish beat (carrying the character count) at the
// NUL that ends the format, or an error beat for an unknown directive. A
// single result register sits between the channels: a new command beat is
// taken only when that register is empty or its beat leaves in the same
// cycle, and never while the converter is busy. Literal bytes, %%, %c and
// string bytes are taken at one beat per cycle while the result side does
// not stall. A %u or %d argument runs through the bit-serial converter: a
// shift-and-add-3 phase over the ARG_WIDTH argument bits, then a digit phase
// over the decimal digit positions (10 at the default width), and the next
// command beat waits until the converter is idle again. A %x argument skips
// the shift phase. The converter is the only multi-cycle unit and sets the
// rate for numeric arguments.
// ---------------------------------------------------------------------------
`include "printf_format_streamer_macros.svh"

module printf_format_streamer
  import pfs_pkg::*;
#(
  parameter int unsigned ARG_WIDTH   = 32,
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic     clk,
  input  logic     rst,
  pfs_in_if.sink   cmd,
  pfs_out_if.source res
);

  // Only the low 32 bits of the argument field exist at the port.
  localparam int unsigned ARG_IN_W = (ARG_WIDTH < 32) ? ARG_WIDTH : 32;

  typedef enum logic [1:0] {
    M_IDLE,
    M_PERCENT,
    M_WAIT_ARG,
    M_STRING
  } mode_t;

  mode_t                  mode;
  dir_t                   pending;
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_inc;

  // Result register.
  logic                   ovalid;
  kind_t                  okind;
  logic [7:0]             ochar;
  logic [COUNT_WIDTH-1:0] ocount;
  logic                   olast;

  logic                   out_free;
  logic                   accept;
  logic                   take_dig;
  logic                   end_beat;
  logic [ARG_WIDTH-1:0]   arg_eff;
  logic                   arg_neg;
  conv_req_t              conv_req;
  logic [ARG_WIDTH-1:0]   conv_value;
  conv_stat_t             conv_st;

  assign out_free  = !ovalid || res.ready;
  assign cmd.ready = out_free && !conv_st.busy;
  assign accept    = cmd.valid && cmd.ready;
  assign take_dig  = conv_st.valid && out_free;

  // The count saturates at all ones.
  assign count_inc = (count == '1) ? count : count + COUNT_WIDTH'(1);

  assign arg_eff = ARG_WIDTH'(cmd.arg_value[ARG_IN_W-1:0]);
  assign arg_neg = (pending == DIR_D) && arg_eff[ARG_WIDTH-1];

  // A numeric argument other than %c starts the converter. A negative %d
  // value is converted as its magnitude after the minus sign is sent.
  always_comb begin
    conv_req.start = accept && (mode == M_WAIT_ARG) && (cmd.func == FUNC_NUM)
                     && (pending != DIR_C);
    conv_req.hex   = (pending == DIR_X);
    conv_value     = arg_neg ? -arg_eff : arg_eff;
  end

  // A finish or error beat is being loaded; the count clears with it.
  assign end_beat = accept && (cmd.func == FUNC_FMT) &&
                    (((mode == M_IDLE) && (cmd.data_byte == CH_NUL)) ||
                     ((mode == M_PERCENT) && (cmd.data_byte != CH_PERCENT) &&
                      (cmd.data_byte != CH_S) && (cmd.data_byte != CH_C) &&
                      (cmd.data_byte != CH_U) && (cmd.data_byte != CH_D) &&
                      (cmd.data_byte != CH_X)));

  pfs_conv #(
    .ARG_WIDTH (ARG_WIDTH)
  ) u_conv (
    .clk   (clk),
    .rst   (rst),
    .req   (conv_req),
    .value (conv_value),
    .take  (take_dig),
    .stat  (conv_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= M_IDLE;
      pending <= DIR_C;
      count   <= '0;
      ovalid  <= 1'b0;
    end else begin
      if (res.ready) begin
        ovalid <= 1'b0;
      end

      // Digits from the converter; never coincides with a command beat.
      if (take_dig) begin
        ovalid <= 1'b1;
        okind  <= KIND_CHAR;
        ochar  <= conv_st.ch;
        ocount <= count_inc;
        olast  <= conv_st.last;
        count  <= count_inc;
      end

      if (accept) begin
        case (mode)
          M_IDLE: begin
            if (cmd.func == FUNC_FMT) begin
              if (cmd.data_byte == CH_NUL) begin
                ovalid <= 1'b1;
                okind  <= KIND_DONE;
                ochar  <= CH_NUL;
                ocount <= count;
                olast  <= 1'b1;
                count  <= '0;
              end else if (cmd.data_byte == CH_PERCENT) begin
                mode <= M_PERCENT;
              end else begin
                ovalid <= 1'b1;
                okind  <= KIND_CHAR;
                ochar  <= cmd.data_byte;
                ocount <= count_inc;
                olast  <= 1'b1;
                count  <= count_inc;
              end
            end
          end
          M_PERCENT: begin
            if (cmd.func == FUNC_FMT) begin
              mode <= M_IDLE;
              case (cmd.data_byte)
                CH_PERCENT: begin
                  ovalid <= 1'b1;
                  okind  <= KIND_CHAR;
                  ochar  <= CH_PERCENT;
                  ocount <= count_inc;
                  olast  <= 1'b1;
                  count  <= count_inc;
                end
                CH_S: mode <= M_STRING;
                CH_C: begin
                  mode    <= M_WAIT_ARG;
                  pending <= DIR_C;
                end
                CH_U: begin
                  mode    <= M_WAIT_ARG;
                  pending <= DIR_U;
                end
                CH_D: begin
                  mode    <= M_WAIT_ARG;
                  pending <= DIR_D;
                end
                CH_X: begin
                  mode    <= M_WAIT_ARG;
                  pending <= DIR_X;
                end
                default: begin
                  ovalid <= 1'b1;
                  okind  <= KIND_ERROR;
                  ochar  <= CH_NUL;
                  ocount <= count;
                  olast  <= 1'b1;
                  count  <= '0;
                end
              endcase
            end
          end
          M_WAIT_ARG: begin
            if (cmd.func == FUNC_NUM) begin
              mode <= M_IDLE;
              if (pending == DIR_C) begin
                ovalid <= 1'b1;
                okind  <= KIND_CHAR;
                ochar  <= cmd.arg_value[7:0];
                ocount <= count_inc;
                olast  <= 1'b1;
                count  <= count_inc;
              end else if (arg_neg) begin
                // The digits follow from the converter, so this is not last.
                ovalid <= 1'b1;
                okind  <= KIND_CHAR;
                ochar  <= CH_MINUS;
                ocount <= count_inc;
                olast  <= 1'b0;
                count  <= count_inc;
              end
            end
          end
          M_STRING: begin
            if (cmd.func == FUNC_STR) begin
              if (cmd.data_byte == CH_NUL) begin
                mode <= M_IDLE;
              end else begin
                ovalid <= 1'b1;
                okind  <= KIND_CHAR;
                ochar  <= cmd.data_byte;
                ocount <= count_inc;
                olast  <= 1'b1;
                count  <= count_inc;
              end
            end
          end
          default: begin
            mode <= M_IDLE;
          end
        endcase
      end
    end
  end

  assign res.valid      = ovalid;
  assign res.kind       = okind;
  assign res.out_char   = ochar;
  assign res.char_count = OUT_COUNT_W'(ocount);
  assign res.last       = olast;

  // No command beat may be taken while the converter still owns the stream.
  `PFS_ASSERT_SAME(a_no_accept_in_conv, clk, rst, conv_st.busy, !cmd.ready, "accept in conversion")
  // The final digit of a conversion returns the converter to idle.
  `PFS_ASSERT_NEXT(a_last_digit_ends, clk, rst, take_dig && conv_st.last, !conv_st.busy, "conv busy")
  // A finish or error beat leaves the count cleared.
  `PFS_ASSERT_NEXT(a_end_clears_count, clk, rst, end_beat, (count == '0) && ovalid && olast, "count")

endmodule

### sv/pfs_conv.sv
// ---------------------------------------------------------------------------
// pfs_conv
// Bit-serial number to digit converter. Decimal values pass through a
// shift-and-add-3 register one bit per cycle; hex values load directly.
// Digits then leave most significant first, one per cycle while each is taken,
// with leading zeros dropped.
// ---------------------------------------------------------------------------
module pfs_conv
  import pfs_pkg::*;
#(
  parameter int unsigned ARG_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  conv_req_t            req,
  input  logic [ARG_WIDTH-1:0] value,
  input  logic                 take,
  output conv_stat_t           stat
);

  // Decimal digits needed for ARG_WIDTH bits; also covers the hex digits.
  localparam int unsigned DIGITS  = (ARG_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned BCD_W   = 4 * DIGITS;
  localparam int unsigned MAXCNT  = (ARG_WIDTH > DIGITS) ? ARG_WIDTH : DIGITS;
  localparam int unsigned CNT_W   = $clog2(MAXCNT + 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DABBLE,
    PH_EMIT
  } phase_t;

  phase_t               phase;
  logic [ARG_WIDTH-1:0] bin;
  logic [BCD_W-1:0]     bcd;
  logic [BCD_W-1:0]     bcd_adj;
  logic [CNT_W-1:0]     cnt;
  logic [3:0]           top_digit;
  logic                 final_digit;
  // Set once the first nonzero digit has gone out; zeros after it are kept.
  logic                 lead_done;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  assign top_digit   = bcd[BCD_W-1 -: 4];
  assign final_digit = (cnt == CNT_W'(1));

  assign stat.busy  = (phase != PH_IDLE);
  assign stat.valid = (phase == PH_EMIT) &&
                      ((top_digit != 4'd0) || lead_done || final_digit);
  assign stat.last  = final_digit;
  assign stat.ch    = digit_char(top_digit);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      cnt       <= '0;
      lead_done <= 1'b0;
    end else begin
      case (phase)
        PH_IDLE: begin
          if (req.start) begin
            lead_done <= 1'b0;
            if (req.hex) begin
              bcd   <= BCD_W'(value);
              cnt   <= CNT_W'(DIGITS);
              phase <= PH_EMIT;
            end else begin
              bin   <= value;
              bcd   <= '0;
              cnt   <= CNT_W'(ARG_WIDTH);
              phase <= PH_DABBLE;
            end
          end
        end
        PH_DABBLE: begin
          bcd <= {bcd_adj[BCD_W-2:0], bin[ARG_WIDTH-1]};
          bin <= bin << 1;
          if (final_digit) begin
            cnt   <= CNT_W'(DIGITS);
            phase <= PH_EMIT;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        PH_EMIT: begin
          if (!stat.valid || take) begin
            bcd <= bcd << 4;
            cnt <= cnt - CNT_W'(1);
            if (stat.valid) begin
              lead_done <= 1'b1;
            end
            if (final_digit) begin
              phase <= PH_IDLE;
            end
          end
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
    end
  end

endmodule
